[rtl/core/cfr_pkg.sv]
// Shared constants and types for the command frame receiver.
`default_nettype none

package cfr_pkg;

	// Sizes at or above this limit are rejected.
	localparam int SIZE_LIMIT = 16;
	localparam int IDX_W = $clog2(SIZE_LIMIT);
	localparam logic [8:0] SIZE_LIMIT_9 = 9'(SIZE_LIMIT);

	localparam logic [7:0] QUICK_RESET = 8'd46;

	// Configuration register indexes.
	localparam logic REG_QUICK = 1'b0;
	localparam logic REG_NAK   = 1'b1;

	// Action codes.
	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_CONSUME = 1'b1;

	localparam int RES_W = 23;
	localparam int TDATA_W = 24;

	// Result of one request; store_valid lands in bit 0.
	typedef struct packed {
		logic [7:0] command_code;
		logic       frame_ready;
		logic       nak_valid;
		logic [7:0] store_byte;
		logic [3:0] store_index;
		logic       store_valid;
	} res_t;

endpackage

`default_nettype wire

[rtl/core/cfr_fsm.sv]
// Frame parsing state and per-request result logic.
`default_nettype none

module cfr_fsm
	import cfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic       action,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] quick_code,
	output res_t            res
);

	localparam logic [1:0] PH_CMD  = 2'd0;
	localparam logic [1:0] PH_SIZE = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	logic [1:0]       phase_q, phase_d;
	logic             pending_q, pending_d;
	logic [IDX_W-1:0] rem_q, rem_d;
	logic [7:0]       cmd_q, cmd_d;

	always_comb begin
		phase_d = phase_q;
		pending_d = pending_q;
		rem_d = rem_q;
		cmd_d = cmd_q;
		res = '0;
		if (action == ACT_CONSUME) begin
			// drop any partial or pending frame
			pending_d = 1'b0;
			phase_d = PH_CMD;
		end else if (pending_q) begin
			phase_d = PH_CMD;
			res.nak_valid = 1'b1;
		end else begin
			case (phase_q)
				PH_SIZE: begin
					if ({1'b0, rx_byte} < SIZE_LIMIT_9) begin
						if (rx_byte == 8'd0) begin
							pending_d = 1'b1;
						end else begin
							rem_d = IDX_W'(rx_byte - 8'd1);
							phase_d = PH_DATA;
						end
					end else begin
						phase_d = PH_CMD;
						res.nak_valid = 1'b1;
					end
				end
				PH_DATA: begin
					res.store_valid = 1'b1;
					res.store_index = 4'(rem_q);
					res.store_byte = rx_byte;
					if (rem_q == '0) begin
						pending_d = 1'b1;
					end else begin
						rem_d = rem_q - 1'b1;
					end
				end
				default: begin
					// command wait; the unused code behaves the same
					cmd_d = rx_byte;
					phase_d = PH_SIZE;
					if (rx_byte == quick_code) begin
						pending_d = 1'b1;
					end
				end
			endcase
		end
		res.frame_ready = pending_d;
		res.command_code = cmd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			pending_q <= 1'b0;
			rem_q <= '0;
			cmd_q <= 8'd0;
		end else if (take) begin
			phase_q <= phase_d;
			pending_q <= pending_d;
			rem_q <= rem_d;
			cmd_q <= cmd_d;
		end
	end

	a_store_nak_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.store_valid && res.nak_valid))
		else $error("store and NAK in the same result");

	a_consume_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && action == ACT_CONSUME |=> !pending_q && phase_q == PH_CMD)
		else $error("consume did not clear the pending frame");

	a_pending_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> $past(take) && $past(action) == ACT_BYTE)
		else $error("frame completed without a received byte");

	a_store_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		res.store_valid |-> phase_q == PH_DATA && !pending_q)
		else $error("payload store outside the payload phase");

endmodule

`default_nettype wire

[rtl/core/cfr_out_stage.sv]
// Output register holding one result until the sink takes it.
`default_nettype none

module cfr_out_stage
	import cfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  res_t            in_res,
	output logic            out_valid,
	input  wire logic       out_ready,
	output res_t            out_res
);

	logic valid_q;
	res_t res_q;

	// advance whenever the register is empty or being drained
	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

endmodule

`default_nettype wire

[rtl/core/command_frame_receiver.sv]
// Command frame receiver top level: stream ports, configuration and result register.
//
// Usage: received serial bytes enter on the s_axis channel (tdata = the byte,
// tuser = action: 0 received byte, 1 host consumed the pending frame). Each
// request yields exactly one result on m_axis: a payload store (index and
// byte), a NAK flag, the frame-ready flag and the current command byte.
// Frames are command, size, then size payload bytes stored from the highest
// index down to 0; the quick command code or a size of 0 ends a frame at once.
// Each result is held in the single result register after the parsing logic;
// one request is accepted every cycle while the sink takes the results.
// When the sink stalls, the result register holds and s_axis_tready drops
// until the result is taken; no result is lost or repeated.
// Reset clears the frame state, empties the result register and loads the
// quick command code with 46. Register 0 is the quick command code; register
// 1 (NAK byte) is accepted for the transmit path and not held here. Write
// configuration only while the block is idle.
`default_nettype none

module command_frame_receiver
	import cfr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [7:0]   cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // [7:0] rx_byte
	input  wire logic         s_axis_tuser,  // [0] action
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [0] store_valid, [4:1] store_index, [12:5] store_byte, [13] nak_valid,
	// [14] frame_ready, [22:15] command_code, [23] zero
	output logic [TDATA_W-1:0] m_axis_tdata
);

	logic [7:0] quick_q;
	logic       take;
	res_t       res;
	res_t       out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quick_q <= QUICK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUICK: quick_q <= cfg_data;
				default: quick_q <= quick_q;
			endcase
		end
	end

	assign take = s_axis_tvalid && s_axis_tready;

	cfr_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.action     (s_axis_tuser),
		.rx_byte    (s_axis_tdata),
		.quick_code (quick_q),
		.res        (res)
	);

	cfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {{(TDATA_W - RES_W){1'b0}}, out_res};

endmodule

`default_nettype wire
